/* rtl/core/magma_pkg.sv */
// magma_pkg: constants, S-box table and round function of the Magma cipher core
// used by magma_block_cipher_top; depends on nothing else
`default_nettype none

package magma_pkg;

   localparam int unsigned NUM_ROUNDS    = 32;
   localparam int unsigned NUM_KEY_PAIRS = 4;
   localparam int unsigned HALF_W        = 32;
   localparam int unsigned BLOCK_W       = 2 * HALF_W;
   localparam int unsigned CSR_IDX_W     = 8;
   localparam int unsigned ROUND_KEY_W   = 3;

   typedef logic [HALF_W-1:0]    half_type;
   typedef logic [BLOCK_W-1:0]   block_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // register indexes of the key store
   localparam csr_idx_type REG_KEY_PAIR_0 = csr_idx_type'(0);
   localparam csr_idx_type REG_KEY_PAIR_1 = csr_idx_type'(1);
   localparam csr_idx_type REG_KEY_PAIR_2 = csr_idx_type'(2);
   localparam csr_idx_type REG_KEY_PAIR_3 = csr_idx_type'(3);

   // operation codes
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // row k serves nibble k of the word
   localparam logic [3:0] SBOX [8][16] = '{
      '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
        4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
      '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
        4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
      '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
        4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
      '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
        4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
      '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
        4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
      '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
        4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
      '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
        4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
      '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
        4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
   };

   // round key number for a given round and direction
   function automatic logic [ROUND_KEY_W-1:0] round_key_sel(input int unsigned rnd,
                                                            input logic op);
      logic [ROUND_KEY_W-1:0] low;
      low = ROUND_KEY_W'(rnd % 8);
      if (op == OP_DECRYPT)
         return (rnd < 8) ? low : ~low;
      else
         return (rnd < 24) ? low : ~low;
   endfunction

   // add key, substitute nibbles, rotate left by 11
   function automatic half_type round_func(input half_type half, input half_type key);
      half_type x;
      half_type y;
      x = half + key;
      for (int n = 0; n < 8; n++) begin
         y[4*n +: 4] = SBOX[n][x[4*n +: 4]];
      end
      return {y[20:0], y[31:21]};
   endfunction

endpackage

`default_nettype wire

/* rtl/core/magma_block_cipher_top.sv */
// magma_block_cipher_top: fully unrolled 32-round Magma cipher, one round per stage,
// 256-bit key in four csr registers; depends on magma_pkg
// an accepted req transfer passes the input register and the 32 round stages before rsp_valid
// throughput: one block per cycle while rsp_stall does not hold a result, set by the one-round-per-stage pipeline
// a stalled result holds the whole pipeline; req_stall follows rsp_stall while rsp_valid is high
// reset clears all stage valid bits and the four key registers to zero
`default_nettype none

module magma_block_cipher_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // input channel
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic                       req_operation,
   input  wire magma_pkg::block_type       req_data_in,
   // result channel
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      magma_pkg::block_type       rsp_data_out,
   // configuration channel
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire magma_pkg::csr_idx_type     csr_index,
   input  wire magma_pkg::block_type       csr_wdata
);
   import magma_pkg::*;

   localparam int unsigned NUM_STAGES = NUM_ROUNDS + 1;

   logic      [NUM_STAGES-1:0] valid_ff;
   logic      [NUM_STAGES-1:0] valid_in;
   half_type                   left_ff  [NUM_STAGES];
   half_type                   left_in  [NUM_STAGES];
   half_type                   right_ff [NUM_STAGES];
   half_type                   right_in [NUM_STAGES];
   logic      [NUM_STAGES-1:0] op_ff;
   logic      [NUM_STAGES-1:0] op_in;
   block_type                  key_pair_ff [NUM_KEY_PAIRS];
   half_type                   round_keys  [8];
   logic                       advance;

   // whole pipeline moves unless a result waits on a stalled consumer
   assign advance   = !(valid_ff[NUM_STAGES-1] && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   assign rsp_valid    = valid_ff[NUM_STAGES-1];
   assign rsp_data_out = {left_ff[NUM_STAGES-1], right_ff[NUM_STAGES-1]};

   // key store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEY_PAIRS; i++) begin
            key_pair_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_KEY_PAIR_0: key_pair_ff[0] <= csr_wdata;
            REG_KEY_PAIR_1: key_pair_ff[1] <= csr_wdata;
            REG_KEY_PAIR_2: key_pair_ff[2] <= csr_wdata;
            REG_KEY_PAIR_3: key_pair_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         round_keys[k] = key_pair_ff[k / 2][(k % 2) * HALF_W +: HALF_W];
      end
   end

   // input register
   always_comb begin
      valid_in[0] = req_valid;
      op_in[0]    = req_operation;
      left_in[0]  = req_data_in[BLOCK_W-1:HALF_W];
      right_in[0] = req_data_in[HALF_W-1:0];
   end

   // one round between stage r and stage r+1
   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      localparam logic [ROUND_KEY_W-1:0] ENC_SEL = round_key_sel(r, OP_ENCRYPT);
      localparam logic [ROUND_KEY_W-1:0] DEC_SEL = round_key_sel(r, OP_DECRYPT);
      half_type key;
      half_type mixed;

      always_comb begin
         key   = (op_ff[r] == OP_DECRYPT) ? round_keys[DEC_SEL] : round_keys[ENC_SEL];
         mixed = left_ff[r] ^ round_func(right_ff[r], key);
         valid_in[r+1] = valid_ff[r];
         op_in[r+1]    = op_ff[r];
         if (r == NUM_ROUNDS - 1) begin
            // last round keeps the halves in place
            left_in[r+1]  = mixed;
            right_in[r+1] = right_ff[r];
         end else begin
            left_in[r+1]  = right_ff[r];
            right_in[r+1] = mixed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff <= op_in;
         for (int s = 0; s < NUM_STAGES; s++) begin
            left_ff[s]  <= left_in[s];
            right_ff[s] <= right_in[s];
         end
      end
   end

   // a held result freezes the valid and op bits of every stage
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(valid_ff) && $stable(op_ff)))
      else $error("pipeline moved while result was stalled");

   // an accepted transfer lands in the input stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (valid_ff[0] && op_ff[0] == $past(req_operation)))
      else $error("accepted request not captured");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> (valid_ff == '0))
      else $error("valid bits not cleared by reset");

   // the input stage advances into stage 1 when the pipeline moves
   assert property (@(posedge clock) disable iff (reset)
      (advance && valid_ff[0]) |=> valid_ff[1])
      else $error("stage valid lost between stages");

endmodule

`default_nettype wire
